FILE: rtl/ncs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncs_pkg
// Shared constants, types and helper functions for the nearest center
// assignment block.
// ----------------------------------------------------------------------------
package ncs_pkg;

  localparam int MAX_CENTERS = 16;
  localparam int COORD_BITS  = 24;

  localparam int SLOT_W     = 4;
  localparam int CFG_W      = 5;
  localparam int OUT_IDX_W  = 4;
  localparam int DIST_OUT_W = 50;

  localparam int SQ_W  = 2 * COORD_BITS;
  localparam int SUM_W = SQ_W + 2;

  localparam int LEVELS = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 0;
  localparam int TREE_N = 1 << LEVELS;
  localparam int IDX_W  = (LEVELS > 0) ? LEVELS : 1;

  localparam int IN_DATA_W  = ((SLOT_W + 3 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((OUT_IDX_W + DIST_OUT_W + 7) / 8) * 8;

  localparam logic KIND_LOAD     = 1'b0;
  localparam logic KIND_CLASSIFY = 1'b1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef coord_t [2:0] point_t;

  typedef struct packed {
    logic             used;
    logic [IDX_W-1:0] idx;
    logic [SUM_W-1:0] sq_dist;
  } node_t;

  function automatic logic [COORD_BITS-1:0] abs_diff(coord_t a, coord_t b);
    logic [COORD_BITS:0] d;
    d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
    if (d[COORD_BITS]) begin
      return COORD_BITS'(-d);
    end
    return COORD_BITS'(d);
  endfunction

  function automatic node_t pick(node_t lo, node_t hi);
    if (hi.used && (!lo.used || hi.sq_dist < lo.sq_dist)) begin
      return hi;
    end
    return lo;
  endfunction

endpackage

FILE: rtl/ncs_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncs_lane
// One center register set with a three-stage squared distance pipeline:
// absolute differences, squares, then the sum of the three squares.
// ----------------------------------------------------------------------------
module ncs_lane (
  input  logic                      clk,
  input  logic                      en,
  input  logic                      wr_en,
  input  ncs_pkg::point_t           wr_pt,
  input  ncs_pkg::point_t           pt,
  output logic [ncs_pkg::SUM_W-1:0] dist_sq
);

  ncs_pkg::point_t                                   ctr_r;
  logic [2:0][ncs_pkg::COORD_BITS-1:0]               diff_r;
  logic [2:0][ncs_pkg::COORD_BITS-1:0]               diff_nxt;
  logic [2:0][ncs_pkg::SQ_W-1:0]                     sq_r;
  logic [ncs_pkg::SUM_W-1:0]                         dist_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ctr_r <= wr_pt;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff_nxt[k] = ncs_pkg::abs_diff(ctr_r[k], pt[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      diff_r <= diff_nxt;
      for (int k = 0; k < 3; k++) begin
        sq_r[k] <= ncs_pkg::SQ_W'(diff_r[k]) * ncs_pkg::SQ_W'(diff_r[k]);
      end
      dist_r <= ncs_pkg::SUM_W'(sq_r[0]) + ncs_pkg::SUM_W'(sq_r[1])
              + ncs_pkg::SUM_W'(sq_r[2]);
    end
  end

  assign dist_sq = dist_r;

endmodule

FILE: rtl/ncs_min_tree.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncs_min_tree
// Registered binary minimum tree over all lane distances. Lanes beyond the
// configured count are masked out, and ties keep the lower index.
// ----------------------------------------------------------------------------
module ncs_min_tree (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  logic                                             en,
  input  logic                                             in_valid,
  input  logic [ncs_pkg::MAX_CENTERS-1:0]                  lane_used,
  input  logic [ncs_pkg::MAX_CENTERS-1:0][ncs_pkg::SUM_W-1:0] lane_dist,
  output logic                                             out_valid,
  output ncs_pkg::node_t                                   out_node
);

  ncs_pkg::node_t node_r [2*ncs_pkg::TREE_N-1];
  logic [ncs_pkg::LEVELS:0] vld_r;

  for (genvar i = 0; i < ncs_pkg::TREE_N; i++) begin : g_leaf
    if (i < ncs_pkg::MAX_CENTERS) begin : g_real
      always_ff @(posedge clk) begin
        if (en) begin
          node_r[ncs_pkg::TREE_N-1+i] <= '{used:    lane_used[i],
                                           idx:     ncs_pkg::IDX_W'(i),
                                           sq_dist: lane_dist[i]};
        end
      end
    end else begin : g_pad
      always_ff @(posedge clk) begin
        if (en) begin
          node_r[ncs_pkg::TREE_N-1+i] <= '{used:    1'b0,
                                           idx:     ncs_pkg::IDX_W'(i),
                                           sq_dist: '0};
        end
      end
    end
  end

  for (genvar k = 0; k < ncs_pkg::TREE_N - 1; k++) begin : g_node
    always_ff @(posedge clk) begin
      if (en) begin
        node_r[k] <= ncs_pkg::pick(node_r[2*k+1], node_r[2*k+2]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= (ncs_pkg::LEVELS+1)'({vld_r, in_valid});
    end
  end

  assign out_valid = vld_r[ncs_pkg::LEVELS];
  assign out_node  = node_r[0];

endmodule

FILE: rtl/nearest_center_assign.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_center_assign
// Nearest-center assignment in three dimensions over up to MAX_CENTERS
// centers held in registers, all distances computed in parallel lanes.
// ----------------------------------------------------------------------------
// Pipeline: 3 distance stages plus log2(MAX_CENTERS)+1 tree stages.
// Throughput: one transaction per cycle; the output register stalls the
// whole pipeline while out_tvalid is high and out_tready is low.
// Reset clears all valid bits and sets the center count to 1; the center
// registers keep their contents and must be loaded before use.
module nearest_center_assign (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [ncs_pkg::CFG_W-1:0]         cfg_wr_data,  // centers_in_use
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // center_slot, coord_x, coord_y, coord_z, zero fill
  input  logic [ncs_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic                              in_tuser,     // kind
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // cluster_index, nearest_distance_sq, zero fill
  output logic [ncs_pkg::OUT_DATA_W-1:0]    out_tdata
);

  logic [ncs_pkg::CFG_W-1:0]  cfg_r;
  logic [2:0]                 v_r;
  logic                       en;
  logic                       accept;
  logic [ncs_pkg::SLOT_W-1:0] slot;
  ncs_pkg::point_t            pt;
  logic [ncs_pkg::MAX_CENTERS-1:0]                      lane_used;
  logic [ncs_pkg::MAX_CENTERS-1:0][ncs_pkg::SUM_W-1:0]  lane_dist;
  ncs_pkg::node_t             root;

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;
  assign accept    = in_tvalid && in_tready;
  assign slot      = in_tdata[ncs_pkg::SLOT_W-1:0];

  for (genvar k = 0; k < 3; k++) begin : g_coord
    assign pt[k] = in_tdata[ncs_pkg::SLOT_W + k*ncs_pkg::COORD_BITS +: ncs_pkg::COORD_BITS];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= ncs_pkg::CFG_W'(1);
    end else if (cfg_wr_en) begin
      cfg_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[1:0], accept && (in_tuser == ncs_pkg::KIND_CLASSIFY)};
    end
  end

  for (genvar i = 0; i < ncs_pkg::MAX_CENTERS; i++) begin : g_lane
    logic wr_en;
    if (i < (1 << ncs_pkg::SLOT_W)) begin : g_wr
      assign wr_en = accept && (in_tuser == ncs_pkg::KIND_LOAD)
                  && (slot == ncs_pkg::SLOT_W'(i));
    end else begin : g_nowr
      assign wr_en = 1'b0;
    end

    assign lane_used[i] = (i == 0) || (32'(i) < 32'(cfg_r));

    ncs_lane u_lane (
      .clk     (clk),
      .en      (en),
      .wr_en   (wr_en),
      .wr_pt   (pt),
      .pt      (pt),
      .dist_sq (lane_dist[i])
    );
  end

  ncs_min_tree u_tree (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v_r[2]),
    .lane_used (lane_used),
    .lane_dist (lane_dist),
    .out_valid (out_tvalid),
    .out_node  (root)
  );

  assign out_tdata = ncs_pkg::OUT_DATA_W'({ncs_pkg::DIST_OUT_W'(root.sq_dist),
                                           ncs_pkg::OUT_IDX_W'(root.idx)});

  a_load_no_result : assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_tuser == ncs_pkg::KIND_LOAD) |=> !v_r[0])
    else $error("load transaction entered the distance pipeline");

  a_classify_enters : assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_tuser == ncs_pkg::KIND_CLASSIFY) |=> v_r[0])
    else $error("classify transaction was dropped at entry");

  a_stall_holds : assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v_r))
    else $error("pipeline valid bits moved during a stall");

  a_index_in_use : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (root.idx == '0) || (32'(root.idx) < 32'(cfg_r)))
    else $error("result index lies beyond the configured center count");

  a_reset_clears : assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && (v_r == '0))
    else $error("valid bits not cleared by reset");

endmodule

FILE: verif/nearest_center_assign_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_center_assign_test
// Self-checking testbench for the nearest center assignment block. A queue fed
// driver sends center loads and point classifications. A local model of the
// center store predicts the nearest center and its squared distance for every
// accepted point. A monitor compares each result with the oldest prediction.
// Both stream sides stall at random outside one steady phase. The center count
// register is changed between phases while the pipeline is empty.
// ----------------------------------------------------------------------------
module nearest_center_assign_test;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int SETTLE_WAIT  = 12;
  localparam int PHASE_ITEMS  = 150;
  localparam int IDLE_PERCENT = 11;

  localparam ncs_pkg::coord_t COORD_MAX = {1'b0, {(ncs_pkg::COORD_BITS-1){1'b1}}};
  localparam ncs_pkg::coord_t COORD_MIN = {1'b1, {(ncs_pkg::COORD_BITS-1){1'b0}}};

  typedef struct packed {
    logic                       kind;
    logic [ncs_pkg::SLOT_W-1:0] slot;
    ncs_pkg::coord_t            x;
    ncs_pkg::coord_t            y;
    ncs_pkg::coord_t            z;
  } item_t;

  typedef struct packed {
    logic [ncs_pkg::OUT_IDX_W-1:0]  idx;
    logic [ncs_pkg::DIST_OUT_W-1:0] sq_dist;
  } assignment_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_wr_en = 1'b0;
  logic [ncs_pkg::CFG_W-1:0]      cfg_wr_data = '0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [ncs_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic                           in_tuser = 1'b0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [ncs_pkg::OUT_DATA_W-1:0] out_tdata;

  item_t       pending_items[$];
  assignment_t expected_assignments[$];
  item_t       cur_item;

  // Center store as the block should see it, and the count register.
  ncs_pkg::coord_t           known_cx[ncs_pkg::MAX_CENTERS];
  ncs_pkg::coord_t           known_cy[ncs_pkg::MAX_CENTERS];
  ncs_pkg::coord_t           known_cz[ncs_pkg::MAX_CENTERS];
  logic [ncs_pkg::CFG_W-1:0] centers_cfg = 5'd1;

  // Centers as seen by the stimulus generator, used to aim points near them.
  ncs_pkg::coord_t gen_cx[ncs_pkg::MAX_CENTERS];
  ncs_pkg::coord_t gen_cy[ncs_pkg::MAX_CENTERS];
  ncs_pkg::coord_t gen_cz[ncs_pkg::MAX_CENTERS];

  int  cycle_count = 0;
  int  errors = 0;
  int  load_count = 0;
  int  classify_count = 0;
  int  checked_count = 0;
  int  config_writes = 0;
  bit  steady = 1'b0;

  nearest_center_assign DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic assignment_t nearest_center(item_t p);
    int               n;
    longint           dx;
    longint           dy;
    longint           dz;
    longint unsigned  d;
    longint unsigned  best_dist;
    int               best_idx;
    assignment_t      r;
    n = (centers_cfg == 0) ? 1 :
        (centers_cfg > ncs_pkg::MAX_CENTERS) ? ncs_pkg::MAX_CENTERS : centers_cfg;
    best_dist = 0;
    best_idx = 0;
    for (int i = 0; i < n; i++) begin
      dx = longint'(known_cx[i]) - longint'(p.x);
      dy = longint'(known_cy[i]) - longint'(p.y);
      dz = longint'(known_cz[i]) - longint'(p.z);
      d = longint'(dx * dx + dy * dy + dz * dz);
      if (i == 0 || d < best_dist) begin
        best_dist = d;
        best_idx = i;
      end
    end
    r.idx = best_idx[ncs_pkg::OUT_IDX_W-1:0];
    r.sq_dist = best_dist[ncs_pkg::DIST_OUT_W-1:0];
    return r;
  endfunction

  function automatic void accept_item(item_t it);
    if (it.kind == ncs_pkg::KIND_LOAD) begin
      known_cx[it.slot] = it.x;
      known_cy[it.slot] = it.y;
      known_cz[it.slot] = it.z;
      load_count++;
    end else begin
      expected_assignments = {expected_assignments, nearest_center(it)};
      classify_count++;
    end
  endfunction

  function automatic void add_load(int slot, ncs_pkg::coord_t x, ncs_pkg::coord_t y,
                                   ncs_pkg::coord_t z);
    item_t it;
    it.kind = ncs_pkg::KIND_LOAD;
    it.slot = slot[ncs_pkg::SLOT_W-1:0];
    it.x = x;
    it.y = y;
    it.z = z;
    gen_cx[slot] = x;
    gen_cy[slot] = y;
    gen_cz[slot] = z;
    pending_items = {pending_items, it};
  endfunction

  function automatic void add_point(ncs_pkg::coord_t x, ncs_pkg::coord_t y,
                                    ncs_pkg::coord_t z);
    item_t it;
    it.kind = ncs_pkg::KIND_CLASSIFY;
    it.slot = ncs_pkg::SLOT_W'($urandom);
    it.x = x;
    it.y = y;
    it.z = z;
    pending_items = {pending_items, it};
  endfunction

  function automatic ncs_pkg::coord_t random_coord();
    int sel;
    sel = $urandom_range(99);
    if (sel < 10) return ($urandom_range(1) == 1) ? COORD_MAX : COORD_MIN;
    if (sel < 25) return ncs_pkg::coord_t'(($urandom_range(8) - 4) * 256);
    return ncs_pkg::coord_t'($urandom);
  endfunction

  function automatic ncs_pkg::coord_t nudge(ncs_pkg::coord_t c);
    return c + ncs_pkg::coord_t'($urandom_range(512) - 256);
  endfunction

  function automatic void add_random_items(int count);
    int sel;
    int s;
    int t;
    for (int k = 0; k < count; k++) begin
      sel = $urandom_range(99);
      s = $urandom_range(ncs_pkg::MAX_CENTERS - 1);
      if (sel < 25) begin
        t = $urandom_range(ncs_pkg::MAX_CENTERS - 1);
        if (sel < 5) begin
          add_load(s, gen_cx[t], gen_cy[t], gen_cz[t]);
        end else begin
          add_load(s, random_coord(), random_coord(), random_coord());
        end
      end else if (sel < 60) begin
        add_point(nudge(gen_cx[s]), nudge(gen_cy[s]), nudge(gen_cz[s]));
      end else if (sel < 68) begin
        add_point(gen_cx[s], gen_cy[s], gen_cz[s]);
      end else begin
        add_point(random_coord(), random_coord(), random_coord());
      end
    end
  endfunction

  task automatic drain();
    while (pending_items.size() != 0 || in_tvalid || expected_assignments.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic write_centers_in_use(logic [ncs_pkg::CFG_W-1:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    centers_cfg = value;
    config_writes++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        accept_item(cur_item);
      end
      if (!in_tvalid || in_tready) begin
        if (pending_items.size() != 0 && (steady || $urandom_range(99) >= IDLE_PERCENT)) begin
          cur_item = pending_items.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {{(ncs_pkg::IN_DATA_W - ncs_pkg::SLOT_W - 3 * ncs_pkg::COORD_BITS){1'b0}},
                       cur_item.z, cur_item.y, cur_item.x, cur_item.slot};
          in_tuser <= cur_item.kind;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_assignments.size() == 0) begin
          $error("result transaction with no prediction pending: %h", out_tdata);
          errors++;
        end else begin
          assignment_t want;
          want = expected_assignments.pop_front();
          checked_count++;
          if (out_tdata[ncs_pkg::OUT_IDX_W-1:0] !== want.idx) begin
            $error("cluster_index: expected %0d, actual %0d",
                   want.idx, out_tdata[ncs_pkg::OUT_IDX_W-1:0]);
            errors++;
          end
          if (out_tdata[ncs_pkg::OUT_IDX_W +: ncs_pkg::DIST_OUT_W] !== want.sq_dist) begin
            $error("nearest_distance_sq: expected %0d, actual %0d",
                   want.sq_dist, out_tdata[ncs_pkg::OUT_IDX_W +: ncs_pkg::DIST_OUT_W]);
            errors++;
          end
        end
      end
      out_tready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    logic [ncs_pkg::CFG_W-1:0] phase_cfg[6];
    phase_cfg[0] = 5'd16;
    phase_cfg[1] = 5'd1;
    phase_cfg[2] = ncs_pkg::CFG_W'($urandom_range(15, 2));
    phase_cfg[3] = 5'd16;
    phase_cfg[4] = ncs_pkg::CFG_W'($urandom_range(31, 17));
    phase_cfg[5] = ncs_pkg::CFG_W'($urandom_range(16, 1));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // With the reset count of one only slot 0 is compared.
    add_load(0, COORD_MIN, COORD_MIN, COORD_MIN);
    add_point(COORD_MAX, COORD_MAX, COORD_MAX);
    add_point(COORD_MIN, COORD_MIN, COORD_MIN);
    drain();

    write_centers_in_use(5'd16);
    add_load(1, COORD_MAX, COORD_MAX, COORD_MAX);
    add_load(2, '0, '0, '0);
    add_load(3, '0, '0, '0);
    add_load(4, ncs_pkg::coord_t'(1), ncs_pkg::coord_t'(-1), ncs_pkg::coord_t'(256));
    for (int s = 5; s < ncs_pkg::MAX_CENTERS; s++) begin
      add_load(s, ncs_pkg::coord_t'($urandom), ncs_pkg::coord_t'($urandom),
               ncs_pkg::coord_t'($urandom));
    end
    add_point('0, '0, '0);
    add_point(COORD_MAX, COORD_MAX, COORD_MAX);
    add_point(ncs_pkg::coord_t'(-1), ncs_pkg::coord_t'(-1), ncs_pkg::coord_t'(-1));
    add_point(COORD_MIN, COORD_MAX, '0);
    drain();

    // A count of zero behaves as one; counts above the store size saturate.
    write_centers_in_use(5'd0);
    add_point(COORD_MAX, COORD_MAX, COORD_MAX);
    drain();
    write_centers_in_use(5'd31);
    add_point('0, '0, '0);
    drain();

    for (int p = 0; p < 6; p++) begin
      write_centers_in_use(phase_cfg[p]);
      steady = (p == 3);
      add_random_items(PHASE_ITEMS);
      drain();
    end
    steady = 1'b0;

    $display("Checked %0d nearest-center results from %0d point and %0d load transactions,",
             checked_count, classify_count, load_count);
    $display("across %0d center count settings including zero and saturating values.",
             config_writes);
    if (errors == 0 && expected_assignments.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: nearest_center_assign.f
rtl/ncs_pkg.sv
rtl/ncs_lane.sv
rtl/ncs_min_tree.sv
rtl/nearest_center_assign.sv
verif/nearest_center_assign_test.sv
